// ----- rtl/pos_pkg.sv -----
// ----------------------------------------------------------------------------
// pos_pkg
// Shared constants, register map and control types for the proximity
// obstacle steering block.
// ----------------------------------------------------------------------------
package pos_pkg;

  // Configuration register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_OFFSET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_THRESH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JAM_THRESH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_SPEED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURN        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL_TOL       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_LIMIT     = 3'd6;

  localparam int OFFSET_W  = 12;
  localparam int OBS_THR_W = 12;
  localparam int JAM_THR_W = 14;
  localparam int SPEED_W   = 10;
  localparam int TOL_W     = 16;
  localparam int LIMIT_W   = 16;

  localparam logic [OFFSET_W-1:0]  RST_SENSOR_OFFSET = 12'd300;
  localparam logic [OBS_THR_W-1:0] RST_OBS_THRESH    = 12'd3000;
  localparam logic [JAM_THR_W-1:0] RST_JAM_THRESH    = 14'd8000;
  localparam logic [SPEED_W-1:0]   RST_FWD_SPEED     = 10'd400;
  localparam logic [SPEED_W-1:0]   RST_MAX_TURN      = 10'd600;
  localparam logic [TOL_W-1:0]     RST_STILL_TOL     = 16'd131;
  localparam logic [LIMIT_W-1:0]   RST_STUCK_LIMIT   = 16'd500;

  // Lane gains, in hundredths
  localparam int GAIN_FRONT = 12;
  localparam int GAIN_DIAG  = 9;
  localparam int GAIN_SIDE  = 2;
  localparam int NUM_LANES  = 6;

  // x/100 == (x * RECIP_MUL) >> RECIP_SHIFT, exact for x < 2^20
  localparam int RECIP_SHIFT = 27;
  localparam int RECIP_MUL   = (2**27 + 99) / 100;
  localparam int RECIP_W     = 25;

  // Heading
  localparam int HEAD_W      = 16;
  localparam int HEAD_PROD_W = 27;
  localparam int HEAD_SHIFT  = 14;
  localparam int HEAD_TERM_W = 13;
  localparam int HEAD_ROUND  = 2**14 - 1;
  localparam int HEAD_SMALL  = 3276;
  localparam int HEAD_BIG    = 29492;

  localparam int SPD_OUT_W = 12;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int lane_gain(input int lane);
    int g;
    case (lane)
      0, 5:    g = GAIN_FRONT;
      1, 4:    g = GAIN_DIAG;
      default: g = GAIN_SIDE;
    endcase
    return g;
  endfunction

  function automatic int delta_w(input int sensor_bits);
    return max_int(sensor_bits + 4, 14);
  endfunction

  typedef struct packed {
    logic acc;
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic upd;
  } pos_adv_t;

  typedef struct packed {
    logic active;
    logic jam_both;
    logic side_right;
  } pos_obs_t;

  typedef struct packed {
    logic base_zero;
    logic jammed;
    logic obstacle;
    logic uturn;
  } pos_stat_t;

endpackage

// ----- rtl/pos_lane.sv -----
// ----------------------------------------------------------------------------
// pos_lane
// One sensor lane: offset removal with floor at zero, then gain/100 term.
// ----------------------------------------------------------------------------
module pos_lane import pos_pkg::*; #(
  parameter int SENSOR_BITS = 12,
  parameter int GAIN        = 12
) (
  input  logic                   clk,
  input  pos_adv_t               adv,
  input  logic [SENSOR_BITS-1:0] raw_i,
  input  logic [OFFSET_W-1:0]    offset_i,
  output logic [SENSOR_BITS-1:0] p_o,
  output logic [SENSOR_BITS-1:0] q_o
);

  localparam int EW = max_int(SENSOR_BITS, OFFSET_W);
  localparam int PW = SENSOR_BITS + RECIP_W;
  localparam logic [PW-1:0] K = PW'(GAIN * RECIP_MUL);

  logic [EW-1:0]          raw_x, off_x, diff;
  logic [SENSOR_BITS-1:0] p_nxt, p_r, q_nxt, q_r;
  logic [PW-1:0]          prod;

  always_comb begin
    raw_x = EW'(raw_i);
    off_x = EW'(offset_i);
    diff  = raw_x - off_x;
    p_nxt = (raw_x > off_x) ? diff[SENSOR_BITS-1:0] : '0;
    prod  = PW'(p_r) * K;
    q_nxt = SENSOR_BITS'(prod[PW-1:RECIP_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (adv.ld1) begin
      p_r <= p_nxt;
    end
    if (adv.ld2) begin
      q_r <= q_nxt;
    end
  end

  assign p_o = p_r;
  assign q_o = q_r;

endmodule

// ----- rtl/pos_merge.sv -----
// ----------------------------------------------------------------------------
// pos_merge
// Combines the lanes: front maximum, side sums, threshold tests and the
// avoidance sums for each side.
// ----------------------------------------------------------------------------
module pos_merge import pos_pkg::*; #(
  parameter int SENSOR_BITS = 12
) (
  input  logic                     clk,
  input  pos_adv_t                 adv,
  input  logic [SENSOR_BITS-1:0]   p_i [NUM_LANES],
  input  logic [SENSOR_BITS-1:0]   q_i [NUM_LANES],
  input  logic [OBS_THR_W-1:0]     obs_thr_i,
  input  logic [JAM_THR_W-1:0]     jam_thr_i,
  output pos_obs_t                 obs_o,
  output logic [SENSOR_BITS+1:0]   sum_r_o,
  output logic [SENSOR_BITS+1:0]   sum_l_o
);

  localparam int SUMW = SENSOR_BITS + 2;
  localparam int TW   = max_int(SENSOR_BITS, OBS_THR_W);
  localparam int JW   = max_int(SUMW, JAM_THR_W);

  logic [SENSOR_BITS-1:0] f_r, f_l, front;
  logic [SUMW-1:0]        act_r, act_l, sr_nxt, sl_nxt;
  logic [SUMW-1:0]        sum_r_r, sum_l_r;
  pos_obs_t               obs_nxt, obs2_r, obs3_r;

  always_comb begin
    f_r   = (p_i[0] > p_i[1]) ? p_i[0] : p_i[1];
    f_l   = (p_i[5] > p_i[4]) ? p_i[5] : p_i[4];
    front = (f_r > f_l) ? f_r : f_l;
    act_r = SUMW'(p_i[0]) + SUMW'(p_i[1]) + SUMW'(p_i[2]);
    act_l = SUMW'(p_i[5]) + SUMW'(p_i[4]) + SUMW'(p_i[3]);
    obs_nxt.active     = TW'(front) > TW'(obs_thr_i);
    obs_nxt.jam_both   = (JW'(act_r) > JW'(jam_thr_i)) && (JW'(act_l) > JW'(jam_thr_i));
    obs_nxt.side_right = act_r > act_l;
    sr_nxt = SUMW'(q_i[0]) + SUMW'(q_i[1]) + SUMW'(q_i[2]);
    sl_nxt = SUMW'(q_i[5]) + SUMW'(q_i[4]) + SUMW'(q_i[3]);
  end

  always_ff @(posedge clk) begin
    if (adv.ld2) begin
      obs2_r <= obs_nxt;
    end
    if (adv.ld3) begin
      obs3_r  <= obs2_r;
      sum_r_r <= sr_nxt;
      sum_l_r <= sl_nxt;
    end
  end

  assign obs_o   = obs3_r;
  assign sum_r_o = sum_r_r;
  assign sum_l_o = sum_l_r;

endmodule

// ----- rtl/pos_steer.sv -----
// ----------------------------------------------------------------------------
// pos_steer
// Heading term, stillness detection and the per-tick state update
// (jam flag, obstacle side, U-turn latch, still counter).
// ----------------------------------------------------------------------------
module pos_steer import pos_pkg::*; #(
  parameter int SENSOR_BITS = 12,
  parameter int POS_BITS    = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pos_adv_t                        adv,
  input  logic signed [HEAD_W-1:0]        heading_i,
  input  logic signed [POS_BITS-1:0]      pos_x_i,
  input  logic signed [POS_BITS-1:0]      pos_y_i,
  input  logic [SPEED_W-1:0]              fwd_i,
  input  logic [SPEED_W-1:0]              maxt_i,
  input  logic [TOL_W-1:0]                tol_i,
  input  logic [LIMIT_W-1:0]              limit_i,
  input  pos_obs_t                        obs_i,
  input  logic [SENSOR_BITS+1:0]          sum_r_i,
  input  logic [SENSOR_BITS+1:0]          sum_l_i,
  output logic signed [delta_w(SENSOR_BITS)-1:0] delta_o,
  output pos_stat_t                       stat_o
);

  localparam int DW   = delta_w(SENSOR_BITS);
  localparam int PW   = POS_BITS + 1;
  localparam int CMPW = max_int(COUNT_BITS, LIMIT_W);

  // stage 1
  logic signed [POS_BITS-1:0]    prev_x_r, prev_y_r;
  logic signed [PW-1:0]          dx_nxt, dy_nxt, dx1_r, dy1_r;
  logic signed [HEAD_PROD_W-1:0] hp_nxt, hp1_r, hp_adj;
  logic [HEAD_W:0]               hx, mag;
  logic                          small_nxt, big_nxt, pos_nxt;
  logic                          small1_r, big1_r, pos1_r;
  // stage 2
  logic [PW-1:0]                 adx, ady;
  logic                          still_nxt, still2_r, small2_r, big2_r, pos2_r;
  logic signed [HEAD_TERM_W-1:0] head_nxt, head2_r;
  // stage 3
  logic                          still3_r, small3_r, big3_r, pos3_r;
  logic signed [HEAD_TERM_W-1:0] head3_r;
  // state
  logic                          jam_r, side_r, uturn_r;
  logic                          jam_nxt, side_nxt, uturn_nxt, steer_en, base_zero;
  logic [COUNT_BITS-1:0]         cnt_r, cnt_nxt;
  logic signed [DW-1:0]          avoid, turn, head_x, mt_x, delta_nxt, delta4_r;
  pos_stat_t                     stat_nxt, stat4_r;

  always_comb begin
    dx_nxt    = PW'(prev_x_r) - PW'(pos_x_i);
    dy_nxt    = PW'(prev_y_r) - PW'(pos_y_i);
    hp_nxt    = HEAD_PROD_W'($signed({1'b0, fwd_i})) * HEAD_PROD_W'(heading_i);
    hx        = {heading_i[HEAD_W-1], heading_i};
    mag       = heading_i[HEAD_W-1] ? (~hx + 1'b1) : hx;
    small_nxt = mag <= (HEAD_W+1)'(HEAD_SMALL);
    big_nxt   = mag >= (HEAD_W+1)'(HEAD_BIG);
    pos_nxt   = ~heading_i[HEAD_W-1] && (heading_i != '0);
  end

  always_comb begin
    adx       = dx1_r[PW-1] ? PW'(-dx1_r) : PW'(dx1_r);
    ady       = dy1_r[PW-1] ? PW'(-dy1_r) : PW'(dy1_r);
    still_nxt = (adx < PW'(tol_i)) && (ady < PW'(tol_i));
    hp_adj    = hp1_r[HEAD_PROD_W-1] ? (hp1_r + HEAD_PROD_W'(HEAD_ROUND)) : hp1_r;
    head_nxt  = hp_adj[HEAD_PROD_W-1:HEAD_SHIFT];
  end

  always_comb begin
    jam_nxt  = obs_i.active & (jam_r | obs_i.jam_both);
    side_nxt = (obs_i.active & ~jam_r) ? obs_i.side_right : side_r;
    if (still3_r) begin
      cnt_nxt = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
    end else begin
      cnt_nxt = (cnt_r == '0) ? cnt_r : cnt_r - 1'b1;
    end
    steer_en = ~jam_nxt && (CMPW'(cnt_nxt) < CMPW'(limit_i));

    avoid = '0;
    if (~uturn_r && obs_i.active) begin
      avoid = side_nxt ? DW'($signed({1'b0, sum_r_i})) : -DW'($signed({1'b0, sum_l_i}));
    end

    head_x    = DW'(head3_r);
    mt_x      = DW'($signed({1'b0, maxt_i}));
    uturn_nxt = uturn_r;
    base_zero = 1'b0;
    turn      = '0;
    if (steer_en) begin
      if (small3_r) begin
        uturn_nxt = 1'b0;
        turn      = head_x;
      end else if (uturn_r || big3_r) begin
        uturn_nxt = 1'b1;
        base_zero = 1'b1;
        turn      = pos3_r ? mt_x : -mt_x;
      end else begin
        turn = head_x;
      end
    end
    delta_nxt          = avoid + turn;
    stat_nxt.base_zero = base_zero;
    stat_nxt.jammed    = jam_nxt;
    stat_nxt.obstacle  = obs_i.active;
    stat_nxt.uturn     = uturn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      jam_r    <= 1'b0;
      side_r   <= 1'b1;
      uturn_r  <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (adv.acc) begin
        prev_x_r <= pos_x_i;
        prev_y_r <= pos_y_i;
      end
      if (adv.upd) begin
        jam_r   <= jam_nxt;
        side_r  <= side_nxt;
        uturn_r <= uturn_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld1) begin
      dx1_r    <= dx_nxt;
      dy1_r    <= dy_nxt;
      hp1_r    <= hp_nxt;
      small1_r <= small_nxt;
      big1_r   <= big_nxt;
      pos1_r   <= pos_nxt;
    end
    if (adv.ld2) begin
      still2_r <= still_nxt;
      head2_r  <= head_nxt;
      small2_r <= small1_r;
      big2_r   <= big1_r;
      pos2_r   <= pos1_r;
    end
    if (adv.ld3) begin
      still3_r <= still2_r;
      head3_r  <= head2_r;
      small3_r <= small2_r;
      big3_r   <= big2_r;
      pos3_r   <= pos2_r;
    end
    if (adv.ld4) begin
      delta4_r <= delta_nxt;
      stat4_r  <= stat_nxt;
    end
  end

  assign delta_o = delta4_r;
  assign stat_o  = stat4_r;

endmodule

// ----- rtl/proximity_obstacle_steering_top.sv -----
// ----------------------------------------------------------------------------
// proximity_obstacle_steering_top
// Wheel speed commands from heading, position and six proximity readings.
//
// Input channel (in_*): one request per control tick, valid/ready.
// Output channel (out_*): one result per request, in order, valid/ready.
// Config channel (cfg_*): register index and data, always ready; write only
// while no request is in flight.
// A request passes the stage 1 to 4 registers, then the output register.
// Throughput: one request per cycle while the receiver keeps up; six sensor
// lanes run side by side and the state update (jam, side, U-turn, still
// counter) is a single stage. The pipeline is five registers deep; a stalled
// receiver holds the output register and upstream stages keep filling, so
// in_ready only falls once all five stages hold a request.
// Reset: registers return to their defaults, the jam and U-turn latches
// clear, the obstacle side is right, still counter and last position are 0.
// ----------------------------------------------------------------------------
module proximity_obstacle_steering_top import pos_pkg::*; #(
  parameter int SENSOR_BITS = 12,
  parameter int POS_BITS    = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [SENSOR_BITS-1:0]      in_prox_right_front,
  input  logic [SENSOR_BITS-1:0]      in_prox_right_diag,
  input  logic [SENSOR_BITS-1:0]      in_prox_right_side,
  input  logic [SENSOR_BITS-1:0]      in_prox_right_rear,
  input  logic [SENSOR_BITS-1:0]      in_prox_left_rear,
  input  logic [SENSOR_BITS-1:0]      in_prox_left_side,
  input  logic [SENSOR_BITS-1:0]      in_prox_left_diag,
  input  logic [SENSOR_BITS-1:0]      in_prox_left_front,
  input  logic signed [HEAD_W-1:0]    in_heading_error,
  input  logic signed [POS_BITS-1:0]  in_pos_x,
  input  logic signed [POS_BITS-1:0]  in_pos_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SPD_OUT_W-1:0] out_left_speed,
  output logic signed [SPD_OUT_W-1:0] out_right_speed,
  output logic                        out_jammed,
  output logic                        out_obstacle_seen,
  output logic                        out_turning_around,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int DW   = delta_w(SENSOR_BITS);
  localparam int SUMW = SENSOR_BITS + 2;

  logic [OFFSET_W-1:0]  offset_r;
  logic [OBS_THR_W-1:0] obs_thr_r;
  logic [JAM_THR_W-1:0] jam_thr_r;
  logic [SPEED_W-1:0]   fwd_r, maxt_r;
  logic [TOL_W-1:0]     tol_r;
  logic [LIMIT_W-1:0]   limit_r;

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic ld_out;
  pos_adv_t adv;

  logic [SENSOR_BITS-1:0] raw  [NUM_LANES];
  logic [SENSOR_BITS-1:0] p    [NUM_LANES];
  logic [SENSOR_BITS-1:0] q    [NUM_LANES];
  pos_obs_t               obs;
  logic [SUMW-1:0]        sum_r, sum_l;
  logic signed [DW-1:0]   delta4, mt_x, d_cl, base_x, left_w, right_w;
  pos_stat_t              stat4;

  logic signed [SPD_OUT_W-1:0] left_r, right_r;
  logic                        jammed_r, obstacle_r, uturn_r;
  logic signed [SPD_OUT_W:0]   spd_spread, spd_lim;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= RST_SENSOR_OFFSET;
      obs_thr_r <= RST_OBS_THRESH;
      jam_thr_r <= RST_JAM_THRESH;
      fwd_r     <= RST_FWD_SPEED;
      maxt_r    <= RST_MAX_TURN;
      tol_r     <= RST_STILL_TOL;
      limit_r   <= RST_STUCK_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SENSOR_OFFSET:   offset_r  <= cfg_data[OFFSET_W-1:0];
        CFG_OBSTACLE_THRESH: obs_thr_r <= cfg_data[OBS_THR_W-1:0];
        CFG_JAM_THRESH:      jam_thr_r <= cfg_data[JAM_THR_W-1:0];
        CFG_FORWARD_SPEED:   fwd_r     <= cfg_data[SPEED_W-1:0];
        CFG_MAX_TURN:        maxt_r    <= cfg_data[SPEED_W-1:0];
        CFG_STILL_TOL:       tol_r     <= cfg_data[TOL_W-1:0];
        CFG_STUCK_LIMIT:     limit_r   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  always_comb begin
    ld_out   = !out_valid_r || out_ready;
    adv.ld4  = !v4_r || ld_out;
    adv.ld3  = !v3_r || adv.ld4;
    adv.ld2  = !v2_r || adv.ld3;
    adv.ld1  = !v1_r || adv.ld2;
    adv.acc  = in_valid && adv.ld1;
    adv.upd  = v3_r && adv.ld4;
  end

  assign in_ready = adv.ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv.ld1) v1_r <= in_valid;
      if (adv.ld2) v2_r <= v1_r;
      if (adv.ld3) v3_r <= v2_r;
      if (adv.ld4) v4_r <= v3_r;
      if (ld_out)  out_valid_r <= v4_r;
    end
  end

  // lanes
  assign raw[0] = in_prox_right_front;
  assign raw[1] = in_prox_right_diag;
  assign raw[2] = in_prox_right_side;
  assign raw[3] = in_prox_left_side;
  assign raw[4] = in_prox_left_diag;
  assign raw[5] = in_prox_left_front;

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    pos_lane #(
      .SENSOR_BITS (SENSOR_BITS),
      .GAIN        (lane_gain(k))
    ) u_lane (
      .clk      (clk),
      .adv      (adv),
      .raw_i    (raw[k]),
      .offset_i (offset_r),
      .p_o      (p[k]),
      .q_o      (q[k])
    );
  end

  pos_merge #(
    .SENSOR_BITS (SENSOR_BITS)
  ) u_merge (
    .clk       (clk),
    .adv       (adv),
    .p_i       (p),
    .q_i       (q),
    .obs_thr_i (obs_thr_r),
    .jam_thr_i (jam_thr_r),
    .obs_o     (obs),
    .sum_r_o   (sum_r),
    .sum_l_o   (sum_l)
  );

  pos_steer #(
    .SENSOR_BITS (SENSOR_BITS),
    .POS_BITS    (POS_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_steer (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .heading_i (in_heading_error),
    .pos_x_i   (in_pos_x),
    .pos_y_i   (in_pos_y),
    .fwd_i     (fwd_r),
    .maxt_i    (maxt_r),
    .tol_i     (tol_r),
    .limit_i   (limit_r),
    .obs_i     (obs),
    .sum_r_i   (sum_r),
    .sum_l_i   (sum_l),
    .delta_o   (delta4),
    .stat_o    (stat4)
  );

  // turn clamp and wheel mix
  always_comb begin
    mt_x = DW'($signed({1'b0, maxt_r}));
    if (delta4 > mt_x) begin
      d_cl = mt_x;
    end else if (delta4 < -mt_x) begin
      d_cl = -mt_x;
    end else begin
      d_cl = delta4;
    end
    base_x  = stat4.base_zero ? '0 : DW'($signed({1'b0, fwd_r}));
    left_w  = base_x - d_cl;
    right_w = base_x + d_cl;
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      left_r     <= left_w[SPD_OUT_W-1:0];
      right_r    <= right_w[SPD_OUT_W-1:0];
      jammed_r   <= stat4.jammed;
      obstacle_r <= stat4.obstacle;
      uturn_r    <= stat4.uturn;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_speed     = left_r;
  assign out_right_speed    = right_r;
  assign out_jammed         = jammed_r;
  assign out_obstacle_seen  = obstacle_r;
  assign out_turning_around = uturn_r;

  // checks
  assign spd_spread = $signed({right_r[SPD_OUT_W-1], right_r}) -
                      $signed({left_r[SPD_OUT_W-1], left_r});
  assign spd_lim    = $signed({2'b00, maxt_r, 1'b0});

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_jam_needs_obstacle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_jammed || out_obstacle_seen))
    else $error("jam flag without obstacle");

  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && v3_r && v4_r && out_valid_r && !out_ready))
    else $error("input stalled with free pipeline stage");

  a_turn_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((spd_spread <= spd_lim) && (spd_spread >= -spd_lim)))
    else $error("turn term beyond clamp");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for proximity_obstacle_steering_top. Control ticks are
// queued by the stimulus process and sent by a clocked driver with random
// gaps. Each accepted request is run through a local steering predictor.
// A clocked monitor stalls at random and compares every wheel command with
// the oldest prediction. The run goes through several register settings.
// ----------------------------------------------------------------------------
module tb import pos_pkg::*; ();

  localparam int SENS_W = 12;
  localparam int POS_W  = 32;

  typedef struct packed {
    logic [SENS_W-1:0]       right_front;
    logic [SENS_W-1:0]       right_diag;
    logic [SENS_W-1:0]       right_side;
    logic [SENS_W-1:0]       right_rear;
    logic [SENS_W-1:0]       left_rear;
    logic [SENS_W-1:0]       left_side;
    logic [SENS_W-1:0]       left_diag;
    logic [SENS_W-1:0]       left_front;
    logic signed [HEAD_W-1:0] heading;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
  } tick_req_t;

  typedef struct packed {
    logic signed [SPD_OUT_W-1:0] left_cmd;
    logic signed [SPD_OUT_W-1:0] right_cmd;
    logic                        jammed;
    logic                        obstacle_seen;
    logic                        turning_around;
  } wheel_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [SENS_W-1:0]           in_prox_right_front = '0;
  logic [SENS_W-1:0]           in_prox_right_diag = '0;
  logic [SENS_W-1:0]           in_prox_right_side = '0;
  logic [SENS_W-1:0]           in_prox_right_rear = '0;
  logic [SENS_W-1:0]           in_prox_left_rear = '0;
  logic [SENS_W-1:0]           in_prox_left_side = '0;
  logic [SENS_W-1:0]           in_prox_left_diag = '0;
  logic [SENS_W-1:0]           in_prox_left_front = '0;
  logic signed [HEAD_W-1:0]    in_heading_error = '0;
  logic signed [POS_W-1:0]     in_pos_x = '0;
  logic signed [POS_W-1:0]     in_pos_y = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [SPD_OUT_W-1:0] out_left_speed;
  logic signed [SPD_OUT_W-1:0] out_right_speed;
  logic                        out_jammed;
  logic                        out_obstacle_seen;
  logic                        out_turning_around;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  proximity_obstacle_steering_top #(
    .SENSOR_BITS(SENS_W),
    .POS_BITS   (POS_W),
    .COUNT_BITS (16)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_prox_right_front(in_prox_right_front),
    .in_prox_right_diag(in_prox_right_diag),
    .in_prox_right_side(in_prox_right_side),
    .in_prox_right_rear(in_prox_right_rear),
    .in_prox_left_rear (in_prox_left_rear),
    .in_prox_left_side (in_prox_left_side),
    .in_prox_left_diag (in_prox_left_diag),
    .in_prox_left_front(in_prox_left_front),
    .in_heading_error  (in_heading_error),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_left_speed    (out_left_speed),
    .out_right_speed   (out_right_speed),
    .out_jammed        (out_jammed),
    .out_obstacle_seen (out_obstacle_seen),
    .out_turning_around(out_turning_around),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register copies
  logic [OFFSET_W-1:0]  cfg_offset = RST_SENSOR_OFFSET;
  logic [OBS_THR_W-1:0] cfg_obs_thr = RST_OBS_THRESH;
  logic [JAM_THR_W-1:0] cfg_jam_thr = RST_JAM_THRESH;
  logic [SPEED_W-1:0]   cfg_fwd = RST_FWD_SPEED;
  logic [SPEED_W-1:0]   cfg_turn = RST_MAX_TURN;
  logic [TOL_W-1:0]     cfg_tol = RST_STILL_TOL;
  logic [LIMIT_W-1:0]   cfg_stuck = RST_STUCK_LIMIT;

  // steering state copies
  logic        jam_st = 1'b0;
  logic        uturn_st = 1'b0;
  logic        side_right_st = 1'b1;
  logic [15:0] still_cnt = '0;
  longint      last_x = 0;
  longint      last_y = 0;

  tick_req_t  tick_q[$];
  wheel_cmd_t wheel_cmd_q[$];
  tick_req_t  cur_req;
  int unsigned send_gap = 0;
  logic        send_burst = 1'b0;
  int unsigned recv_hold = 0;
  logic        recv_burst = 1'b0;
  int unsigned bad_cnt = 0;
  logic signed [POS_W-1:0] gen_x = '0;
  logic signed [POS_W-1:0] gen_y = '0;

  task automatic steer_predict(input tick_req_t r, output wheel_cmd_t c);
    longint raw[8];
    longint p[8];
    longint front, act_r, act_l, base, delta, x, y, dx, dy, ang, mag;
    logic [63:0] spd;
    logic active;
    raw[0] = longint'(r.right_front);
    raw[1] = longint'(r.right_diag);
    raw[2] = longint'(r.right_side);
    raw[3] = longint'(r.right_rear);
    raw[4] = longint'(r.left_rear);
    raw[5] = longint'(r.left_side);
    raw[6] = longint'(r.left_diag);
    raw[7] = longint'(r.left_front);
    for (int i = 0; i < 8; i++) begin
      p[i] = raw[i] - longint'(cfg_offset);
      if (p[i] < 0) p[i] = 0;
    end
    front = p[0];
    if (p[1] > front) front = p[1];
    if (p[6] > front) front = p[6];
    if (p[7] > front) front = p[7];
    act_r = p[0] + p[1] + p[2];
    act_l = p[7] + p[6] + p[5];

    active = front > longint'(cfg_obs_thr);
    if (!active) jam_st = 1'b0;
    if (active && !jam_st) begin
      if (act_r > longint'(cfg_jam_thr) && act_l > longint'(cfg_jam_thr)) jam_st = 1'b1;
      side_right_st = act_r > act_l;
    end

    base = longint'(cfg_fwd);
    delta = 0;
    if (!uturn_st && active) begin
      if (!side_right_st)
        delta = -((2 * p[5]) / 100 + (9 * p[6]) / 100 + (12 * p[7]) / 100);
      else
        delta = (2 * p[2]) / 100 + (9 * p[1]) / 100 + (12 * p[0]) / 100;
    end

    x = longint'(r.pos_x);
    y = longint'(r.pos_y);
    dx = last_x - x;
    dy = last_y - y;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dx < longint'(cfg_tol) && dy < longint'(cfg_tol)) begin
      if (still_cnt != 16'hffff) still_cnt = still_cnt + 16'd1;
    end else if (still_cnt != 16'd0) begin
      still_cnt = still_cnt - 16'd1;
    end
    last_x = x;
    last_y = y;

    ang = longint'(r.heading);
    mag = (ang < 0) ? -ang : ang;
    if (!jam_st && still_cnt < cfg_stuck) begin
      if (mag <= HEAD_SMALL) begin
        uturn_st = 1'b0;
        delta = delta + (longint'(cfg_fwd) * ang) / 16384;
      end else if (uturn_st || mag >= HEAD_BIG) begin
        uturn_st = 1'b1;
        base = 0;
        delta = delta + ((ang > 0) ? longint'(cfg_turn) : -longint'(cfg_turn));
      end else begin
        delta = delta + (longint'(cfg_fwd) * ang) / 16384;
      end
    end
    if (delta > longint'(cfg_turn)) delta = longint'(cfg_turn);
    if (delta < -longint'(cfg_turn)) delta = -longint'(cfg_turn);

    spd = base - delta;
    c.left_cmd = spd[SPD_OUT_W-1:0];
    spd = base + delta;
    c.right_cmd = spd[SPD_OUT_W-1:0];
    c.jammed = jam_st;
    c.obstacle_seen = active;
    c.turning_around = uturn_st;
  endtask

  function automatic int unsigned draw_wait(ref logic burst);
    if ($urandom_range(0, 39) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        wheel_cmd_t e;
        steer_predict(cur_req, e);
        wheel_cmd_q.insert(wheel_cmd_q.size(), e);
        send_gap = draw_wait(send_burst);
      end
      if (!in_valid || in_ready) begin
        if (send_gap == 0 && tick_q.size() > 0) begin
          cur_req = tick_q.pop_front();
          in_prox_right_front <= cur_req.right_front;
          in_prox_right_diag  <= cur_req.right_diag;
          in_prox_right_side  <= cur_req.right_side;
          in_prox_right_rear  <= cur_req.right_rear;
          in_prox_left_rear   <= cur_req.left_rear;
          in_prox_left_side   <= cur_req.left_side;
          in_prox_left_diag   <= cur_req.left_diag;
          in_prox_left_front  <= cur_req.left_front;
          in_heading_error    <= cur_req.heading;
          in_pos_x            <= cur_req.pos_x;
          in_pos_y            <= cur_req.pos_y;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        wheel_cmd_t got, e;
        got = '{out_left_speed, out_right_speed, out_jammed, out_obstacle_seen,
                out_turning_around};
        if (wheel_cmd_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10) $display("unexpected wheel command at %0t", $realtime);
        end else begin
          e = wheel_cmd_q.pop_front();
          if (got !== e) begin
            bad_cnt++;
            if (bad_cnt <= 10)
              $display("mismatch %0t exp L%0d R%0d j%b o%b u%b got L%0d R%0d j%b o%b u%b",
                       $realtime, e.left_cmd, e.right_cmd, e.jammed, e.obstacle_seen,
                       e.turning_around, got.left_cmd, got.right_cmd, got.jammed,
                       got.obstacle_seen, got.turning_around);
          end
        end
        recv_hold = draw_wait(recv_burst);
      end else if (recv_hold > 0) begin
        recv_hold--;
      end
      out_ready <= (recv_hold == 0);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SENSOR_OFFSET:   cfg_offset  = val[OFFSET_W-1:0];
      CFG_OBSTACLE_THRESH: cfg_obs_thr = val[OBS_THR_W-1:0];
      CFG_JAM_THRESH:      cfg_jam_thr = val[JAM_THR_W-1:0];
      CFG_FORWARD_SPEED:   cfg_fwd     = val[SPEED_W-1:0];
      CFG_MAX_TURN:        cfg_turn    = val[SPEED_W-1:0];
      CFG_STILL_TOL:       cfg_tol     = val[TOL_W-1:0];
      CFG_STUCK_LIMIT:     cfg_stuck   = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int unsigned off, thr, jam, fwd, turn, tol, lim);
    write_reg(CFG_SENSOR_OFFSET, off);
    write_reg(CFG_OBSTACLE_THRESH, thr);
    write_reg(CFG_JAM_THRESH, jam);
    write_reg(CFG_FORWARD_SPEED, fwd);
    write_reg(CFG_MAX_TURN, turn);
    write_reg(CFG_STILL_TOL, tol);
    write_reg(CFG_STUCK_LIMIT, lim);
  endtask

  function automatic tick_req_t mk_tick(int rf, rd, rs, ls, ld, lf, hd, int x, int y);
    tick_req_t r;
    r.right_front = SENS_W'(rf);
    r.right_diag  = SENS_W'(rd);
    r.right_side  = SENS_W'(rs);
    r.right_rear  = 12'hfff ^ SENS_W'(rs);
    r.left_rear   = 12'hfff ^ SENS_W'(ls);
    r.left_side   = SENS_W'(ls);
    r.left_diag   = SENS_W'(ld);
    r.left_front  = SENS_W'(lf);
    r.heading     = HEAD_W'(hd);
    r.pos_x       = x;
    r.pos_y       = y;
    return r;
  endfunction

  function automatic logic [SENS_W-1:0] rand_prox(int kind);
    int v;
    case (kind)
      0: v = $urandom_range(0, 4095);
      1: v = $urandom_range(0, (cfg_offset + 64 > 4095) ? 4095 : cfg_offset + 64);
      2: v = int'(cfg_offset) + int'(cfg_obs_thr) + int'($urandom_range(0, 64)) - 32;
      default: v = $urandom_range(3000, 4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SENS_W'(v);
  endfunction

  function automatic int rand_heading();
    int edges[12] = '{3276, -3276, 3277, -3277, 29491, -29491, 29492, -29492,
                      -32768, 32767, 0, -1};
    case ($urandom_range(0, 5))
      0: return int'($urandom_range(0, 6552)) - 3276;
      1: return int'($urandom_range(0, 3275)) + 29492;
      2: return -(int'($urandom_range(0, 3276)) + 29492);
      3: return edges[$urandom_range(0, 11)];
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int rand_step(int unsigned mode);
    int span;
    span = (mode < 6) ? int'(cfg_tol) / 2 : 2 * int'(cfg_tol) + 2;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic tick_req_t rand_tick();
    tick_req_t r;
    int rk, lk;
    int unsigned pm;
    rk = $urandom_range(0, 3);
    lk = $urandom_range(0, 3);
    r.right_front = rand_prox(rk);
    r.right_diag  = rand_prox(rk);
    r.right_side  = rand_prox(rk);
    r.right_rear  = SENS_W'($urandom_range(0, 4095));
    r.left_rear   = SENS_W'($urandom_range(0, 4095));
    if ($urandom_range(0, 7) == 0) begin
      r.left_side  = r.right_side;
      r.left_diag  = r.right_diag;
      r.left_front = r.right_front;
    end else begin
      r.left_side  = rand_prox(lk);
      r.left_diag  = rand_prox(lk);
      r.left_front = rand_prox(lk);
    end
    r.heading = HEAD_W'(rand_heading());
    pm = $urandom_range(0, 9);
    if (pm == 0) begin
      gen_x = $urandom;
      gen_y = $urandom;
    end else begin
      gen_x = gen_x + rand_step(pm);
      gen_y = gen_y + rand_step(pm);
    end
    r.pos_x = gen_x;
    r.pos_y = gen_y;
    return r;
  endfunction

  task automatic add_tick(input tick_req_t r);
    tick_q.insert(tick_q.size(), r);
  endtask

  task automatic run_phase(int n);
    repeat (n) add_tick(rand_tick());
    while (tick_q.size() != 0 || in_valid || wheel_cmd_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stim
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, jam set and cleared, both sides, tie, threshold edge
    add_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_tick(mk_tick(4095, 4095, 4095, 4095, 4095, 4095, 32767,
                     32'h7fffffff, 32'h7fffffff));
    add_tick(mk_tick(4095, 4095, 4095, 4095, 4095, 4095, -32768,
                     32'h80000000, 32'h80000000));
    add_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_tick(mk_tick(4000, 0, 0, 0, 0, 0, 0, 1000, 1000));
    add_tick(mk_tick(0, 3900, 4095, 0, 0, 0, 1000, 5000, -5000));
    add_tick(mk_tick(0, 0, 0, 2000, 3500, 4095, -1000, 9000, 200));
    add_tick(mk_tick(3400, 0, 0, 0, 0, 3400, 0, 9000, 200));
    add_tick(mk_tick(3300, 0, 0, 0, 0, 0, 0, 20000, 200));
    add_tick(mk_tick(3301, 0, 0, 0, 0, 0, 0, 20050, 250));
    // heading bands and the latched turn
    add_tick(mk_tick(0, 0, 0, 0, 0, 0, 3276, 40000, 0));
    add_tick(mk_tick(0, 0, 0, 0, 0, 0, -3276, 80000, 0));
    add_tick(mk_tick(0, 0, 0, 0, 0, 0, 3277, 120000, 0));
    add_tick(mk_tick(0, 0, 0, 0, 0, 0, -3277, 160000, 0));
    add_tick(mk_tick(0, 0, 0, 0, 0, 0, 29491, 200000, 0));
    add_tick(mk_tick(0, 0, 0, 0, 0, 0, 29492, 240000, 0));
    add_tick(mk_tick(0, 0, 0, 0, 0, 0, 10000, 280000, 0));
    add_tick(mk_tick(4000, 100, 900, 0, 0, 0, -5000, 320000, 0));
    add_tick(mk_tick(0, 0, 0, 0, 0, 0, 3276, 360000, 0));
    add_tick(mk_tick(0, 0, 0, 0, 0, 0, -29492, 400000, 0));
    add_tick(mk_tick(0, 0, 0, 3000, 3800, 3900, -32768, 440000, 0));
    run_phase(200);

    write_all(0, 0, 0, 0, 0, 0, 0);
    run_phase(150);
    write_all(4095, 4095, 12285, 1000, 1000, 65535, 65535);
    run_phase(150);
    repeat (6) begin
      write_all(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 600),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                            : $urandom_range(500, 3600),
                $urandom_range(0, 12285),
                $urandom_range(0, 1000),
                $urandom_range(0, 1000),
                $urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom_range(0, 65535),
                $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 65535));
      run_phase(225);
    end

    repeat (20) @(posedge clk);
    if (bad_cnt == 0 && wheel_cmd_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- proximity_obstacle_steering_top.f -----
rtl/pos_pkg.sv
rtl/pos_lane.sv
rtl/pos_merge.sv
rtl/pos_steer.sv
rtl/proximity_obstacle_steering_top.sv
dv/tb.sv
